// ===== rtl/core/tnn_pkg.sv =====
// ----------------------------------------------------------------------------
// tnn_pkg
// Shared constants and types for the nearest-neighbor selection list.
// ----------------------------------------------------------------------------
package tnn_pkg;

    localparam int MAX_NEIGHBORS = 16;
    localparam int SLOT_W        = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
    localparam int CFG_W         = 7;
    localparam int KEY_W         = 32;
    localparam int ID_W          = 32;
    localparam int RANK_W        = 6;

    localparam logic [CFG_W-1:0] NEIGHBORS_RESET = CFG_W'(16);
    localparam logic [KEY_W-1:0] EMPTY_KEY       = '1;

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_EMIT
    } tnn_state_t;

    typedef struct packed {
        logic              insert_en;
        logic              clear;
        logic              load_out;
        logic [SLOT_W-1:0] out_idx;
        logic              out_last;
        logic [CNT_W-1:0]  n_use;
    } tnn_cmd_t;

endpackage

// ===== rtl/core/tnn_datapath.sv =====
// ----------------------------------------------------------------------------
// tnn_datapath
// Sorted slot list with parallel compare-and-shift insertion, and the
// result register that the list is read out through.
// ----------------------------------------------------------------------------
module tnn_datapath
    import tnn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  tnn_cmd_t            cmd,
    input  logic [KEY_W-1:0]    cand_distance,
    input  logic [ID_W-1:0]     cand_item_id,
    output logic [RANK_W-1:0]   rank,
    output logic                entry_valid,
    output logic [KEY_W-1:0]    entry_distance,
    output logic [ID_W-1:0]     entry_item_id,
    output logic                last_entry
);

    logic [KEY_W-1:0] dist_reg [MAX_NEIGHBORS];
    logic [ID_W-1:0]  id_reg   [MAX_NEIGHBORS];
    logic [MAX_NEIGHBORS-1:0] valid_reg;

    logic [MAX_NEIGHBORS-1:0] in_use;
    logic [MAX_NEIGHBORS-1:0] lt;
    logic [MAX_NEIGHBORS-1:0] hit;
    logic [MAX_NEIGHBORS-1:0] prior;
    logic [MAX_NEIGHBORS-1:0] first_lt;
    logic [MAX_NEIGHBORS-1:0] ins_before;
    logic [MAX_NEIGHBORS-1:0] shift_en;

    logic [RANK_W-1:0] rank_reg;
    logic              entry_valid_reg;
    logic [KEY_W-1:0]  entry_distance_reg;
    logic [ID_W-1:0]   entry_item_id_reg;
    logic              last_entry_reg;

    // per-slot compare, first stopping slot wins
    always_comb
    begin
        for (int j = 0; j < MAX_NEIGHBORS; j++)
        begin
            in_use[j] = (CNT_W'(j) < cmd.n_use);
            lt[j]     = in_use[j] && (cand_distance < dist_reg[j]);
            hit[j]    = lt[j] || (in_use[j] && (cand_distance == dist_reg[j])
                                  && (cand_item_id == id_reg[j]));
        end
        prior[0]      = 1'b0;
        ins_before[0] = 1'b0;
        for (int j = 1; j < MAX_NEIGHBORS; j++)
        begin
            prior[j]      = prior[j-1] || hit[j-1];
            ins_before[j] = ins_before[j-1] || (lt[j-1] && !prior[j-1]);
        end
        for (int j = 0; j < MAX_NEIGHBORS; j++)
        begin
            first_lt[j] = lt[j] && !prior[j];
            shift_en[j] = in_use[j] && ins_before[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_NEIGHBORS; k++)
            begin
                dist_reg[k] <= EMPTY_KEY;
                id_reg[k]   <= '0;
            end
            valid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            for (int k = 0; k < MAX_NEIGHBORS; k++)
            begin
                dist_reg[k] <= EMPTY_KEY;
                id_reg[k]   <= '0;
            end
            valid_reg <= '0;
        end
        else if (cmd.insert_en)
        begin
            for (int k = 0; k < MAX_NEIGHBORS; k++)
            begin
                if (first_lt[k])
                begin
                    dist_reg[k]  <= cand_distance;
                    id_reg[k]    <= cand_item_id;
                    valid_reg[k] <= 1'b1;
                end
                else if (shift_en[k] && (k > 0))
                begin
                    dist_reg[k]  <= dist_reg[(k > 0) ? k - 1 : 0];
                    id_reg[k]    <= id_reg[(k > 0) ? k - 1 : 0];
                    valid_reg[k] <= valid_reg[(k > 0) ? k - 1 : 0];
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rank_reg           <= RANK_W'(cmd.out_idx);
            entry_valid_reg    <= valid_reg[cmd.out_idx];
            entry_distance_reg <= dist_reg[cmd.out_idx];
            entry_item_id_reg  <= id_reg[cmd.out_idx];
            last_entry_reg     <= cmd.out_last;
        end
    end

    assign rank           = rank_reg;
    assign entry_valid    = entry_valid_reg;
    assign entry_distance = entry_distance_reg;
    assign entry_item_id  = entry_item_id_reg;
    assign last_entry     = last_entry_reg;

endmodule

// ===== rtl/core/tnn_ctrl.sv =====
// ----------------------------------------------------------------------------
// tnn_ctrl
// Handshake control, neighbor-count register and read-out sequencer.
// ----------------------------------------------------------------------------
module tnn_ctrl
    import tnn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             last_candidate,
    output logic             out_valid,
    input  logic             out_ready,
    output tnn_cmd_t         cmd
);

    tnn_state_t       state_reg, state_next;
    logic [CFG_W-1:0] neighbors_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] n_hold_reg, n_hold_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] n_use;
    logic             accept;
    logic             can_load;
    logic             at_end;

    // clamp to 1..MAX_NEIGHBORS
    always_comb
    begin
        if (neighbors_reg == '0)
            n_use = CNT_W'(1);
        else if (neighbors_reg > CFG_W'(MAX_NEIGHBORS))
            n_use = CNT_W'(MAX_NEIGHBORS);
        else
            n_use = CNT_W'(neighbors_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            neighbors_reg <= NEIGHBORS_RESET;
            cnt_reg       <= '0;
            n_hold_reg    <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_hold_reg    <= n_hold_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                neighbors_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_hold_next    = n_hold_reg;
        in_ready       = 1'b0;
        accept         = 1'b0;
        can_load       = !out_valid_reg || out_ready;
        at_end         = (cnt_reg + CNT_W'(1)) == n_hold_reg;
        cmd            = '0;
        cmd.n_use      = n_use;
        cmd.out_idx    = cnt_reg[SLOT_W-1:0];
        cmd.out_last   = at_end;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_COLLECT:
            begin
                in_ready      = 1'b1;
                accept        = in_valid;
                cmd.insert_en = accept;
                if (accept && last_candidate)
                begin
                    state_next  = ST_EMIT;
                    cnt_next    = '0;
                    n_hold_next = n_use;
                end
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    cnt_next       = cnt_reg + CNT_W'(1);
                    if (at_end)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/top_n_nearest_selector_top.sv =====
// ----------------------------------------------------------------------------
// top_n_nearest_selector_top
// Keeps the nearest candidates of a query in a sorted list and reports it.
// ----------------------------------------------------------------------------
// A candidate request is taken every cycle while a query is being collected:
// all slots compare against it in parallel and the list shifts in the same
// cycle. The request marked last_candidate is inserted too, then the list is
// read out through the output register (rank 0 first), one slot per cycle
// unless out_ready stalls it, giving neighbors_wanted results clamped to
// 1..16, after which the list is cleared. No input is taken during the
// read-out. A neighbors_wanted write takes effect from the next accepted
// request; the read-out length is fixed when the last request is taken.
module top_n_nearest_selector_top
    import tnn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KEY_W-1:0]    cand_distance,
    input  logic [ID_W-1:0]     cand_item_id,
    input  logic                last_candidate,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [RANK_W-1:0]   rank,
    output logic                entry_valid,
    output logic [KEY_W-1:0]    entry_distance,
    output logic [ID_W-1:0]     entry_item_id,
    output logic                last_entry
);

    tnn_cmd_t cmd;

    tnn_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .last_candidate (last_candidate),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cmd            (cmd)
    );

    tnn_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cand_distance  (cand_distance),
        .cand_item_id   (cand_item_id),
        .rank           (rank),
        .entry_valid    (entry_valid),
        .entry_distance (entry_distance),
        .entry_item_id  (entry_item_id),
        .last_entry     (last_entry)
    );

endmodule
